// ===== rtl/core/rvpc_pkg.sv =====
// rvpc_pkg: shared types and codes for the release version compare unit
// parser phases, family and order codes, per-side parser state record
// no dependencies
`timescale 1ns / 1ps

package rvpc_pkg;

  typedef enum logic [4:0] {
    PH_START      = 5'd0,
    PH_R_SEEN     = 5'd1,
    PH_MAJ_FIRST  = 5'd2,
    PH_MAJ        = 5'd3,
    PH_MIN_FIRST  = 5'd4,
    PH_MIN        = 5'd5,
    PH_DIST_FIRST = 5'd6,
    PH_DIST       = 5'd7,
    PH_EXP_G      = 5'd8,
    PH_HEX        = 5'd9,
    PH_SUFFIX_D   = 5'd10,
    PH_SUFFIX_I   = 5'd11,
    PH_SUFFIX_R   = 5'd12,
    PH_SUFFIX_T   = 5'd13,
    PH_SUFFIX_Y   = 5'd14,
    PH_EXP_END    = 5'd15,
    PH_DONE_OK    = 5'd16,
    PH_BAD        = 5'd17,
    PH_BAD_DONE   = 5'd18
  } phase_t;

  typedef enum logic [1:0] {
    FAM_NONE = 2'd0,
    FAM_RC   = 2'd1,
    FAM_M    = 2'd2
  } family_t;

  typedef enum logic [1:0] {
    ORD_SAME      = 2'd0,
    ORD_NEWER     = 2'd1,
    ORD_OLDER     = 2'd2,
    ORD_UNORDERED = 2'd3
  } order_t;

  typedef struct packed {
    phase_t      phase;
    family_t     family;
    logic [31:0] major;
    logic [31:0] minor;
    logic [31:0] distance;
    logic [2:0]  hex_count;
  } side_state_t;

  localparam side_state_t SIDE_RESET = '{
    phase:     PH_START,
    family:    FAM_NONE,
    major:     32'd0,
    minor:     32'd0,
    distance:  32'd0,
    hex_count: 3'd0
  };

endpackage

// ===== rtl/core/rvpc_side_parser.sv =====
// rvpc_side_parser: one character step of the release format parser for one side
// also reports whether the string would be well formed if it ended after this step
// depends on rvpc_pkg
`timescale 1ns / 1ps

module rvpc_side_parser #(
  parameter int MIN_HASH_DIGITS = 7
) (
  input  rvpc_pkg::side_state_t cur,
  input  logic [7:0]            ch,
  output rvpc_pkg::side_state_t nxt,
  output logic                  final_ok
);
  import rvpc_pkg::*;

  localparam logic [2:0] MIN_HX  = 3'(MIN_HASH_DIGITS);
  localparam logic [2:0] HEX_SAT = 3'd7;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_M    = 8'h4d;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_I    = 8'h69;
  localparam logic [7:0] CH_LR   = 8'h72;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_Y    = 8'h79;

  logic        is_dec;
  logic        is_hex;
  logic [3:0]  digit;
  logic [31:0] num_sel;
  logic [35:0] acc;
  logic        write_num;
  logic [31:0] new_num;
  phase_t      fail_ph;
  logic [7:0]  suffix_exp;

  assign is_dec = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_hex = is_dec || ((ch >= 8'h61) && (ch <= 8'h66)) ||
                  ((ch >= 8'h41) && (ch <= 8'h46));
  assign digit  = ch[3:0];

  always_comb begin
    if (cur.phase == PH_MAJ_FIRST || cur.phase == PH_MAJ) begin
      num_sel = cur.major;
    end else if (cur.phase == PH_MIN_FIRST || cur.phase == PH_MIN) begin
      num_sel = cur.minor;
    end else begin
      num_sel = cur.distance;
    end
  end

  // times ten plus digit, overflow shows in the top four bits
  assign acc = ({4'd0, num_sel} << 3) + ({4'd0, num_sel} << 1) + {32'd0, digit};

  always_comb begin
    unique case (cur.phase)
      PH_SUFFIX_D: suffix_exp = CH_D;
      PH_SUFFIX_I: suffix_exp = CH_I;
      PH_SUFFIX_R: suffix_exp = CH_LR;
      PH_SUFFIX_T: suffix_exp = CH_T;
      default:     suffix_exp = CH_Y;
    endcase
  end

  always_comb begin
    nxt       = cur;
    write_num = 1'b0;
    new_num   = 32'd0;
    fail_ph   = (ch == CH_NUL) ? PH_BAD_DONE : PH_BAD;
    unique case (cur.phase)
      PH_START: begin
        if (ch == CH_R) begin
          nxt.phase = PH_R_SEEN;
        end else if (ch == CH_M) begin
          nxt.family = FAM_M;
          nxt.phase  = PH_MAJ_FIRST;
        end else begin
          nxt.phase = fail_ph;
        end
      end
      PH_R_SEEN: begin
        if (ch == CH_C) begin
          nxt.family = FAM_RC;
          nxt.phase  = PH_MAJ_FIRST;
        end else begin
          nxt.phase = fail_ph;
        end
      end
      PH_MAJ_FIRST, PH_MIN_FIRST, PH_DIST_FIRST: begin
        if (is_dec) begin
          write_num = 1'b1;
          new_num   = {28'd0, digit};
          nxt.phase = phase_t'(cur.phase + 5'd1);
        end else begin
          nxt.phase = fail_ph;
        end
      end
      PH_MAJ, PH_MIN, PH_DIST: begin
        priority if (is_dec) begin
          if (acc[35:32] != 4'd0) begin
            nxt.phase = PH_BAD;
          end else begin
            write_num = 1'b1;
            new_num   = acc[31:0];
          end
        end else if (ch == CH_DOT && cur.phase == PH_MAJ && cur.family == FAM_M) begin
          nxt.phase = PH_MIN_FIRST;
        end else if (ch == CH_DASH) begin
          nxt.phase = (cur.phase == PH_DIST) ? PH_EXP_G : PH_DIST_FIRST;
        end else if (ch == CH_NUL && cur.phase != PH_DIST) begin
          nxt.phase = PH_DONE_OK;
        end else begin
          nxt.phase = fail_ph;
        end
      end
      PH_EXP_G: begin
        if (ch == CH_G) begin
          nxt.hex_count = 3'd0;
          nxt.phase     = PH_HEX;
        end else begin
          nxt.phase = fail_ph;
        end
      end
      PH_HEX: begin
        priority if (is_hex) begin
          if (cur.hex_count != HEX_SAT) begin
            nxt.hex_count = cur.hex_count + 3'd1;
          end
        end else if (cur.hex_count < MIN_HX) begin
          nxt.phase = fail_ph;
        end else if (ch == CH_NUL) begin
          nxt.phase = PH_DONE_OK;
        end else if (ch == CH_DASH) begin
          nxt.phase = PH_SUFFIX_D;
        end else begin
          nxt.phase = fail_ph;
        end
      end
      PH_SUFFIX_D, PH_SUFFIX_I, PH_SUFFIX_R, PH_SUFFIX_T, PH_SUFFIX_Y: begin
        if (ch == suffix_exp) begin
          nxt.phase = phase_t'(cur.phase + 5'd1);
        end else begin
          nxt.phase = fail_ph;
        end
      end
      PH_EXP_END: begin
        nxt.phase = (ch == CH_NUL) ? PH_DONE_OK : fail_ph;
      end
      PH_DONE_OK, PH_BAD_DONE: begin
        nxt.phase = cur.phase;
      end
      PH_BAD: begin
        if (ch == CH_NUL) begin
          nxt.phase = PH_BAD_DONE;
        end
      end
      default: begin
        nxt.phase = fail_ph;
      end
    endcase
    if (write_num) begin
      if (cur.phase == PH_MAJ_FIRST || cur.phase == PH_MAJ) begin
        nxt.major = new_num;
      end else if (cur.phase == PH_MIN_FIRST || cur.phase == PH_MIN) begin
        nxt.minor = new_num;
      end else begin
        nxt.distance = new_num;
      end
    end
  end

  // phases that a terminating zero turns into a good end
  assign final_ok = (nxt.phase == PH_MAJ) || (nxt.phase == PH_MIN) ||
                    (nxt.phase == PH_EXP_END) || (nxt.phase == PH_DONE_OK) ||
                    ((nxt.phase == PH_HEX) && (nxt.hex_count >= MIN_HX));

endmodule

// ===== rtl/core/rvpc_order_decide.sv =====
// rvpc_order_decide: picks the order code from both parsed versions
// exact match first, then validity, then family, major, minor, distance
// depends on rvpc_pkg
`timescale 1ns / 1ps

module rvpc_order_decide (
  input  logic                  strings_match,
  input  logic                  offered_ok,
  input  logic                  running_ok,
  input  rvpc_pkg::side_state_t offered,
  input  rvpc_pkg::side_state_t running,
  output rvpc_pkg::order_t      order
);
  import rvpc_pkg::*;

  always_comb begin
    priority if (strings_match) begin
      order = ORD_SAME;
    end else if (!offered_ok || !running_ok) begin
      order = ORD_UNORDERED;
    end else if (offered.family != running.family) begin
      order = (offered.family > running.family) ? ORD_NEWER : ORD_OLDER;
    end else if (offered.major != running.major) begin
      order = (offered.major > running.major) ? ORD_NEWER : ORD_OLDER;
    end else if (offered.minor != running.minor) begin
      order = (offered.minor > running.minor) ? ORD_NEWER : ORD_OLDER;
    end else if (offered.distance != running.distance) begin
      order = (offered.distance > running.distance) ? ORD_NEWER : ORD_OLDER;
    end else begin
      order = ORD_UNORDERED;
    end
  end

endmodule

// ===== rtl/core/release_version_parse_compare_unit.sv =====
// release_version_parse_compare_unit: top level of the release version compare unit
// input register, two side parsers, order decision, result register
// depends on rvpc_pkg, rvpc_side_parser, rvpc_order_decide
`timescale 1ns / 1ps

// Each input beat carries one character of the offered and of the running version
// string; the beat with final_position high closes the pair and yields one order beat.
// The unit takes one beat per clock while the input does not stall: a beat is held in
// the input register, then one character parser step with a decimal times-ten accumulate
// per side updates the state and, for a final beat, loads the result register, from
// which the order is driven on the output. The input stalls only while a final beat
// in the input register waits for an earlier order that is still held on the output.
// The state returns to its start values after every final beat, ready for the next pair.
module release_version_parse_compare_unit #(
  parameter int MIN_HASH_DIGITS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] offered_char,
  input  logic [7:0] running_char,
  input  logic       final_position,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] order
);
  import rvpc_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_offered;
  logic [7:0]  s1_running;
  logic        s1_final;
  logic        advance;
  logic        out_free;

  side_state_t off_st;
  side_state_t run_st;
  side_state_t off_next;
  side_state_t run_next;
  logic        strings_match;
  logic        off_ok;
  logic        run_ok;
  logic [7:0]  off_eff;
  logic [7:0]  run_eff;
  order_t      order_next;
  logic [1:0]  order_q;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && (!s1_final || out_free);
  assign in_ready = !s1_valid || advance;

  // a side that already ended sees zero characters
  assign off_eff = (off_st.phase == PH_DONE_OK || off_st.phase == PH_BAD_DONE) ?
                   8'h00 : s1_offered;
  assign run_eff = (run_st.phase == PH_DONE_OK || run_st.phase == PH_BAD_DONE) ?
                   8'h00 : s1_running;

  rvpc_side_parser #(
    .MIN_HASH_DIGITS(MIN_HASH_DIGITS)
  ) u_off_parser (
    .cur      (off_st),
    .ch       (off_eff),
    .nxt      (off_next),
    .final_ok (off_ok)
  );

  rvpc_side_parser #(
    .MIN_HASH_DIGITS(MIN_HASH_DIGITS)
  ) u_run_parser (
    .cur      (run_st),
    .ch       (run_eff),
    .nxt      (run_next),
    .final_ok (run_ok)
  );

  rvpc_order_decide u_decide (
    .strings_match (strings_match && (off_eff == run_eff)),
    .offered_ok    (off_ok),
    .running_ok    (run_ok),
    .offered       (off_next),
    .running       (run_next),
    .order         (order_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_offered <= offered_char;
      s1_running <= running_char;
      s1_final   <= final_position;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      off_st        <= SIDE_RESET;
      run_st        <= SIDE_RESET;
      strings_match <= 1'b1;
    end else if (advance) begin
      if (s1_final) begin
        off_st        <= SIDE_RESET;
        run_st        <= SIDE_RESET;
        strings_match <= 1'b1;
      end else begin
        off_st        <= off_next;
        run_st        <= run_next;
        strings_match <= strings_match && (off_eff == run_eff);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_final) begin
      order_q <= order_next;
    end
  end

  assign order = order_q;

`ifndef ASSERT_OFF
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && s1_final |=> out_valid)
    else $error("final beat did not produce a result");

  a_state_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && s1_final |=> off_st.phase == PH_START && run_st.phase == PH_START &&
                            strings_match)
    else $error("parser state not restarted after final beat");

  a_nonfinal_no_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_final |-> in_ready)
    else $error("non-final beat stalled the input");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(off_st) && $stable(run_st) && $stable(strings_match))
    else $error("parser state changed without a beat");
`endif

endmodule
